// ----- rtl/hrl_pkg.sv -----
// hrl_pkg: constants and the hex digit decoder for the hex record loader
// no dependencies

package hrl_pkg;

    localparam int ADDR_BITS      = 16;
    localparam int POS_BITS       = 10;
    localparam int ADDR_SUM_BITS  = 17;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;

    localparam logic [POS_BITS-1:0] POS_MAX        = {POS_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] POS_LEN_HI     = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_LEN_LO     = POS_BITS'(2);
    localparam logic [POS_BITS-1:0] POS_ADDR_FIRST = POS_BITS'(3);
    localparam logic [POS_BITS-1:0] POS_ADDR_LAST  = POS_BITS'(6);
    localparam logic [POS_BITS-1:0] POS_TYPE_HI    = POS_BITS'(7);
    localparam logic [POS_BITS-1:0] POS_TYPE_LO    = POS_BITS'(8);
    localparam logic [POS_BITS-1:0] FIRST_DATA_POS = POS_BITS'(9);
    localparam logic [POS_BITS-1:0] ACT_POS        = POS_BITS'(11);

    localparam logic [7:0] BYTE_INDEX_MAX = 8'hFF;

    // wrap mask for the load address, applied before cutting to 16 bits
    localparam logic [ADDR_SUM_BITS-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_SUM_BITS) ? {ADDR_SUM_BITS{1'b1}}
                                     : ADDR_SUM_BITS'((64'd1 << ADDR_BITS) - 64'd1);

    // non-hex characters decode as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n = 4'(c - 8'h61 + 8'd10);
        end
        return n;
    endfunction

endpackage

// ----- rtl/hex_record_loader_core.sv -----
// hex_record_loader_core: decodes the data records of hex text into byte writes
// depends on hrl_pkg
//
// output: registered; a write appears on m_axis in the cycle after the input transfer that releases it
// throughput: one character per cycle while the result side keeps taking
// transfers; the single output register is the only buffering
// reset: synchronous, active low on aresetn; clears record state and output valid

module hex_record_loader_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] write_address, [23:16] write_byte
);
    import hrl_pkg::*;

    logic                in_record_reg, in_record_next;
    logic [POS_BITS-1:0] char_position_reg, char_position_next;
    logic [7:0]          record_length_reg, record_length_next;
    logic [15:0]         record_address_reg, record_address_next;
    logic                type_is_data_reg, type_is_data_next;
    logic [3:0]          high_nibble_reg, high_nibble_next;
    logic [7:0]          byte_index_reg, byte_index_next;
    logic [7:0]          pending_byte_reg, pending_byte_next;
    logic                pending_valid_reg, pending_valid_next;

    logic                out_valid_reg;
    logic [15:0]         out_address_reg, out_address_next;
    logic [7:0]          out_byte_reg, out_byte_next;

    logic                accept;
    logic                emit;
    logic [7:0]          emit_index;
    logic [3:0]          nib;
    logic [7:0]          value;
    logic [ADDR_SUM_BITS-1:0] addr_sum;
    logic [POS_BITS-1:0] p;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign nib   = hex_nibble(s_axis_tdata);
    assign value = {high_nibble_reg, nib};
    assign p     = char_position_reg;

    always_comb begin
        in_record_next      = in_record_reg;
        char_position_next  = char_position_reg;
        record_length_next  = record_length_reg;
        record_address_next = record_address_reg;
        type_is_data_next   = type_is_data_reg;
        high_nibble_next    = high_nibble_reg;
        byte_index_next     = byte_index_reg;
        pending_byte_next   = pending_byte_reg;
        pending_valid_next  = pending_valid_reg;
        emit                = 1'b0;
        emit_index          = byte_index_reg;
        out_byte_next       = value;

        if (s_axis_tdata == COLON_CHAR) begin
            in_record_next      = 1'b1;
            char_position_next  = POS_LEN_HI;
            record_length_next  = 8'd0;
            record_address_next = 16'd0;
            type_is_data_next   = 1'b1;
            high_nibble_next    = 4'd0;
            byte_index_next     = 8'd0;
            pending_byte_next   = 8'd0;
            pending_valid_next  = 1'b0;
        end else if (in_record_reg) begin
            if (p == POS_LEN_LO) begin
                record_length_next = value;
            end else if (p >= POS_ADDR_FIRST && p <= POS_ADDR_LAST) begin
                record_address_next = {record_address_reg[11:0], nib};
            end else if (p == POS_TYPE_HI || p == POS_TYPE_LO) begin
                if (s_axis_tdata != ZERO_CHAR) begin
                    type_is_data_next = 1'b0;
                end
            end else if (p >= FIRST_DATA_POS && p[0]) begin
                // high digit of a data byte; the twelfth character releases the first byte
                if (p == ACT_POS && pending_valid_reg) begin
                    emit               = 1'b1;
                    emit_index         = 8'd0;
                    out_byte_next      = pending_byte_reg;
                    pending_valid_next = 1'b0;
                end
                high_nibble_next = nib;
            end else if (p > FIRST_DATA_POS) begin
                if (type_is_data_reg && byte_index_reg < record_length_reg) begin
                    if (p < ACT_POS) begin
                        pending_byte_next  = value;
                        pending_valid_next = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                if (byte_index_reg != BYTE_INDEX_MAX) begin
                    byte_index_next = byte_index_reg + 8'd1;
                end
            end
            if (p == POS_LEN_HI || p == POS_ADDR_FIRST) begin
                high_nibble_next = nib;
            end
            if (p != POS_MAX) begin
                char_position_next = p + POS_BITS'(1);
            end
        end

        if (s_axis_tlast) begin
            in_record_next     = 1'b0;
            pending_valid_next = 1'b0;
        end
    end

    assign addr_sum         = (ADDR_SUM_BITS'(record_address_reg) + ADDR_SUM_BITS'(emit_index))
                              & ADDR_MASK;
    assign out_address_next = addr_sum[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_record_reg      <= 1'b0;
            char_position_reg  <= '0;
            record_length_reg  <= 8'd0;
            record_address_reg <= 16'd0;
            type_is_data_reg   <= 1'b1;
            high_nibble_reg    <= 4'd0;
            byte_index_reg     <= 8'd0;
            pending_byte_reg   <= 8'd0;
            pending_valid_reg  <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                in_record_reg      <= in_record_next;
                char_position_reg  <= char_position_next;
                record_length_reg  <= record_length_next;
                record_address_reg <= record_address_next;
                type_is_data_reg   <= type_is_data_next;
                high_nibble_reg    <= high_nibble_next;
                byte_index_reg     <= byte_index_next;
                pending_byte_reg   <= pending_byte_next;
                pending_valid_reg  <= pending_valid_next;
                out_valid_reg      <= emit;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_address_reg <= out_address_next;
            out_byte_reg    <= out_byte_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_byte_reg, out_address_reg};

`ifndef SYNTHESIS
    // a pending first byte only lives inside an open record
    a_pending_in_record: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_valid_reg |-> in_record_reg)
        else $error("pending byte outside a record");

    // a marked final character always closes the record
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !in_record_reg)
        else $error("record still open after end of text");

    // a colon opens a record at position one
    a_colon_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast && s_axis_tdata == COLON_CHAR)
        |=> (in_record_reg && char_position_reg == POS_LEN_HI))
        else $error("colon did not open a record");

    // no write comes out before the first data byte has been released
    a_no_early_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && char_position_reg < ACT_POS
         && s_axis_tdata != COLON_CHAR) |=> !m_axis_tvalid)
        else $error("write issued before the twelfth character");
`endif

endmodule
